### hdl/tvka_pkg.sv
// tvka_pkg: shared types and constants for the two-voice key allocator
// no dependencies; imported by every module of the block but tvka_ram
`default_nettype none

package tvka_pkg;

  // number of period registers and width of the register address
  localparam int NUM_PERIOD_REGS = 8;
  localparam int ADDR_W          = 5;
  localparam int SLOT_W          = 5;  // holds key plus one for up to sixteen keys
  localparam int STAMP_W         = 32;

  typedef logic [15:0]       period_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef period_t [NUM_PERIOD_REGS-1:0] period_bank_t;

  localparam period_bank_t PERIOD_RESET = {
    16'd191, 16'd202, 16'd227, 16'd255, 16'd286, 16'd303, 16'd341, 16'd382
  };

  // one entry of the key state memory
  typedef struct packed {
    logic   down;
    stamp_t press_stamp;
    stamp_t last_stamp;
  } key_entry_t;

  // request from the control sequencer to the key engine
  typedef struct packed {
    logic       go;
    logic       is_tick;
    logic       all_rel;
    logic [2:0] key;
    logic       rising;
  } key_cmd_t;

  // status back from the key engine
  typedef struct packed {
    logic  done;
    slot_t cand_one;
    slot_t cand_two;
  } key_stat_t;

  // period and compare values of both voices
  typedef struct packed {
    logic    done;
    period_t period_one;
    period_t compare_one;
    period_t period_two;
    period_t compare_two;
  } tone_res_t;

endpackage

`default_nettype wire

### hdl/two_voice_key_allocator_unit.sv
// two_voice_key_allocator_unit: top level, handshakes, period registers,
// voice assignment; depends on tvka_pkg, tvka_key_engine and tvka_tone
//
// Usage:
// Input items arrive on the s_ channel. s_tuser is the item kind: 0 a
// one-millisecond tick, 1 a key edge. A tick advances time, releases all
// keys when every pin reads high and hands the two voices to two pressed
// keys picked by a press-time scan. An edge updates one key with a per-key
// debounce lockout. Each item yields one result on the m_ channel with the
// key, timer period and 95 percent compare value of both voices.
// The key state memory is read once per key, one key a cycle, during the
// tick scan. One item is in flight at a time; s_tready returns the cycle
// after the result is loaded into the output register.
// A result waiting on a stalled m_tready does not block the next transfer;
// that item's result waits in the tone unit until the output register frees.
// Reset clears time, key state (through per-entry valid bits, no clearing
// pass), voices and the period registers to their default tones.
// The period registers sit on the APB port at byte offsets 4*i.
`default_nettype none

module two_voice_key_allocator_unit #(
  parameter int NUM_KEYS   = 8,
  parameter int LOCKOUT_MS = 90
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // [2:0] key_index, [3] edge_rising, [11:4] pin_levels, [15:12] zero
  input  wire logic [15:0]                 s_tdata,
  // [0] req_type
  input  wire logic                        s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [3:0] voice_one_key, [7:4] voice_two_key, [23:8] voice_one_period,
  // [39:24] voice_one_compare, [55:40] voice_two_period,
  // [71:56] voice_two_compare
  output logic [71:0]                      m_tdata,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tvka_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import tvka_pkg::*;

  localparam logic REQ_TICK = 1'b0;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEY   = 6'b000010,
    S_VOICE = 6'b000100,
    S_START = 6'b001000,
    S_TONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t       state;
  period_bank_t periods;
  slot_t        voice_one_slot;
  slot_t        voice_two_slot;
  logic         tick_q;
  logic         all_rel_q;
  logic         in_xfer;
  logic         out_free;
  logic [2:0]   reg_idx;
  key_cmd_t     kcmd;
  key_stat_t    kstat;
  tone_res_t    tres;
  slot_t        base_one;
  slot_t        base_two;
  slot_t        voice_one_next;
  slot_t        voice_two_next;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[ADDR_W-1:2];
  assign prdata   = {16'd0, periods[reg_idx]};
  assign s_tready = state == S_IDLE;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      periods <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      periods[reg_idx] <= pwdata[15:0];
    end
  end

  assign kcmd.go      = in_xfer;
  assign kcmd.is_tick = s_tuser == REQ_TICK;
  assign kcmd.all_rel = &s_tdata[11:4];
  assign kcmd.key     = s_tdata[2:0];
  assign kcmd.rising  = s_tdata[3];

  tvka_key_engine #(
    .NUM_KEYS  (NUM_KEYS),
    .LOCKOUT_MS(LOCKOUT_MS)
  ) u_key_engine (
    .clk (clk),
    .rst (rst),
    .cmd (kcmd),
    .stat(kstat)
  );

  tvka_tone u_tone (
    .clk     (clk),
    .rst     (rst),
    .go      (state == S_START),
    .slot_one(voice_one_slot),
    .slot_two(voice_two_slot),
    .periods (periods),
    .res     (tres)
  );

  // keep a voice on a key it already holds
  always_comb begin
    base_one       = all_rel_q ? '0 : voice_one_slot;
    base_two       = all_rel_q ? '0 : voice_two_slot;
    voice_one_next = base_one;
    voice_two_next = base_two;
    if ((kstat.cand_one == base_one && kstat.cand_two == base_two) ||
        (kstat.cand_two == base_one && kstat.cand_one == base_two)) begin
      voice_one_next = base_one;
    end else if (kstat.cand_one == base_one) begin
      voice_two_next = kstat.cand_two;
    end else if (kstat.cand_two == base_one) begin
      voice_two_next = kstat.cand_one;
    end else if (kstat.cand_one == base_two) begin
      voice_one_next = kstat.cand_two;
    end else if (kstat.cand_two == base_two) begin
      voice_one_next = kstat.cand_one;
    end else begin
      voice_one_next = kstat.cand_one;
      voice_two_next = kstat.cand_two;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tick_q    <= kcmd.is_tick;
      all_rel_q <= kcmd.is_tick && kcmd.all_rel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      voice_one_slot <= '0;
      voice_two_slot <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_KEY;
          end
        end
        S_KEY: begin
          if (kstat.done) begin
            state <= tick_q ? S_VOICE : S_START;
          end
        end
        S_VOICE: begin
          voice_one_slot <= voice_one_next;
          voice_two_slot <= voice_two_next;
          state          <= S_START;
        end
        S_START: begin
          state <= S_TONE;
        end
        S_TONE: begin
          if (tres.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= {tres.compare_two, tres.period_two, tres.compare_one,
                  tres.period_one, 4'(voice_two_slot), 4'(voice_one_slot)};
    end
  end

endmodule

`default_nettype wire

### hdl/tvka_ram.sv
// tvka_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
`default_nettype none

module tvka_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/tvka_key_engine.sv
// tvka_key_engine: key state memory, edge update and newest-key scan
// depends on tvka_pkg and tvka_ram
`default_nettype none

module tvka_key_engine #(
  parameter int NUM_KEYS   = 8,
  parameter int LOCKOUT_MS = 90
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tvka_pkg::key_cmd_t cmd,
  output tvka_pkg::key_stat_t     stat
);
  import tvka_pkg::*;

  localparam int AW = $clog2(NUM_KEYS);
  localparam int CW = AW + 1;
  localparam int EW = $bits(key_entry_t);

  typedef enum logic [2:0] {
    KE_IDLE = 3'b001,
    KE_EDGE = 3'b010,
    KE_SCAN = 3'b100
  } ke_state_t;

  ke_state_t         state;
  stamp_t            now_ms;
  logic [NUM_KEYS-1:0] vld;
  logic              rd_vld;
  logic [CW-1:0]     rd_cnt;
  logic              proc_pend;
  logic [AW-1:0]     proc_idx;
  logic              all_rel;
  logic              rising;
  logic [AW-1:0]     edge_addr;
  slot_t             cand_one;
  slot_t             cand_two;
  stamp_t            stamp_one;
  stamp_t            stamp_two;
  logic              done;

  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [EW-1:0]     wdata;
  logic [EW-1:0]     rdata;
  key_entry_t        ent;
  key_entry_t        edge_next;
  stamp_t            since;
  logic              in_range;
  logic              scan_more;
  logic              proc_down;
  slot_t             proc_slot;

  tvka_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_KEYS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_range  = int'(cmd.key) < NUM_KEYS;
  assign scan_more = rd_cnt != CW'(NUM_KEYS);

  // entries never written read as the reset value
  assign ent = rd_vld ? key_entry_t'(rdata) : '0;

  // edge update with lockout
  always_comb begin
    since     = now_ms - ent.last_stamp;
    edge_next = ent;
    if (since > STAMP_W'(LOCKOUT_MS)) begin
      if (!rising && !ent.down) begin
        edge_next.down        = 1'b1;
        edge_next.press_stamp = now_ms;
        edge_next.last_stamp  = now_ms;
      end else if (rising && ent.down) begin
        edge_next.down        = 1'b0;
        edge_next.press_stamp = '0;
        edge_next.last_stamp  = now_ms;
      end
    end else if (since != '0) begin
      // bounce inside the lockout restarts it
      edge_next.last_stamp  = now_ms;
      edge_next.press_stamp = '0;
    end
  end

  assign proc_down = ent.down && !all_rel;
  assign proc_slot = SLOT_W'(proc_idx) + SLOT_W'(1);

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (state == KE_IDLE && cmd.go && !cmd.is_tick && in_range) begin
      re    = 1'b1;
      raddr = AW'(cmd.key);
    end else if (state == KE_SCAN && scan_more) begin
      re    = 1'b1;
      raddr = rd_cnt[AW-1:0];
    end
  end

  // each entry is written only in the cycle after its own read, so reads
  // and writes never meet on one address
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state == KE_EDGE) begin
      we    = 1'b1;
      waddr = edge_addr;
      wdata = edge_next;
    end else if (state == KE_SCAN && proc_pend && all_rel) begin
      we    = 1'b1;
      waddr = proc_idx;
      wdata = {1'b0, ent.press_stamp, ent.last_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_vld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= KE_IDLE;
      now_ms    <= '0;
      done      <= 1'b0;
      proc_pend <= 1'b0;
      rd_cnt    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        KE_IDLE: begin
          if (cmd.go) begin
            if (cmd.is_tick) begin
              now_ms    <= now_ms + STAMP_W'(1);
              rd_cnt    <= '0;
              proc_pend <= 1'b0;
              cand_one  <= '0;
              cand_two  <= '0;
              all_rel   <= cmd.all_rel;
              state     <= KE_SCAN;
            end else if (in_range) begin
              rising    <= cmd.rising;
              edge_addr <= AW'(cmd.key);
              state     <= KE_EDGE;
            end else begin
              done <= 1'b1;
            end
          end
        end
        KE_EDGE: begin
          done  <= 1'b1;
          state <= KE_IDLE;
        end
        KE_SCAN: begin
          proc_pend <= scan_more;
          if (scan_more) begin
            rd_cnt   <= rd_cnt + CW'(1);
            proc_idx <= rd_cnt[AW-1:0];
          end
          if (proc_pend && proc_down) begin
            if (cand_one == '0) begin
              cand_one  <= proc_slot;
              stamp_one <= ent.press_stamp;
            end else if (cand_two == '0) begin
              cand_two  <= proc_slot;
              stamp_two <= ent.press_stamp;
            end else if (stamp_one < ent.press_stamp) begin
              cand_one  <= proc_slot;
              stamp_one <= ent.press_stamp;
            end else if (stamp_two < ent.press_stamp) begin
              cand_two  <= proc_slot;
              stamp_two <= ent.press_stamp;
            end
          end
          if (!scan_more && !proc_pend) begin
            done  <= 1'b1;
            state <= KE_IDLE;
          end
        end
        default: state <= KE_IDLE;
      endcase
    end
  end

  assign stat.done     = done;
  assign stat.cand_one = cand_one;
  assign stat.cand_two = cand_two;

endmodule

`default_nettype wire

### hdl/tvka_tone.sv
// tvka_tone: period lookup and 95 percent compare for both voices
// one shared two-stage multiply path, voice one then voice two; uses tvka_pkg
`default_nettype none

module tvka_tone (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   go,
  input  wire tvka_pkg::slot_t        slot_one,
  input  wire tvka_pkg::slot_t        slot_two,
  input  wire tvka_pkg::period_bank_t periods,
  output tvka_pkg::tone_res_t         res
);
  import tvka_pkg::*;

  // floor(p*95/100) = floor(floor(p*19/4)/5); divide by five as
  // multiply by ceil(2^22/5) and shift, exact below 2^22
  localparam logic [4:0]  MUL_NINETEEN = 5'd19;
  localparam logic [19:0] RECIP_FIVE   = 20'd838861;
  localparam int          RECIP_SHIFT  = 22;

  logic        second_pend;
  logic        issue;
  logic        issue_lane;
  slot_t       issue_slot;
  period_t     issue_period;
  logic        s1_vld;
  logic        s1_lane;
  period_t     s1_period;
  logic [20:0] s1_prod;
  logic [38:0] quot_prod;
  period_t     compare;
  logic        done;
  period_t     period_one;
  period_t     compare_one;
  period_t     period_two;
  period_t     compare_two;

  assign issue      = go || second_pend;
  assign issue_lane = second_pend;
  assign issue_slot = issue_lane ? slot_two : slot_one;

  // silent voice and keys without a register play period one
  always_comb begin
    if (issue_slot == '0 || issue_slot > SLOT_W'(NUM_PERIOD_REGS)) begin
      issue_period = 16'd1;
    end else begin
      issue_period = periods[3'(issue_slot - SLOT_W'(1))];
    end
  end

  assign quot_prod = 39'(s1_prod[20:2]) * 39'(RECIP_FIVE);
  assign compare   = quot_prod[RECIP_SHIFT+15:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      second_pend <= 1'b0;
      s1_vld      <= 1'b0;
      done        <= 1'b0;
    end else begin
      second_pend <= go;
      s1_vld      <= issue;
      done        <= s1_vld && s1_lane;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_lane   <= issue_lane;
      s1_period <= issue_period;
      s1_prod   <= 21'(issue_period) * 21'(MUL_NINETEEN);
    end
    if (s1_vld) begin
      if (s1_lane) begin
        period_two  <= s1_period;
        compare_two <= compare;
      end else begin
        period_one  <= s1_period;
        compare_one <= compare;
      end
    end
  end

  assign res.done        = done;
  assign res.period_one  = period_one;
  assign res.compare_one = compare_one;
  assign res.period_two  = period_two;
  assign res.compare_two = compare_two;

endmodule

`default_nettype wire
